FILE: design/environmental_sensor_compensation_assert.svh
// ----------------------------------------------------------------------------
// Environmental sensor compensation assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ENVIRONMENTAL_SENSOR_COMPENSATION_ASSERT_SVH
`define ENVIRONMENTAL_SENSOR_COMPENSATION_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ESC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define ESC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ESC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ESC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: design/esc_pkg.sv
// ----------------------------------------------------------------------------
// Environmental sensor compensation package
// Beat types, register indexes and divider widths shared by the design.
// ----------------------------------------------------------------------------
package esc_pkg;

   // request beat: raw readings
   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
      logic [15:0] raw_humidity;
   } req_beat_type;

   // response beat: compensated values
   typedef struct packed {
      logic signed [31:0] temperature_millicelsius;
      logic [31:0]        pressure_millipascal;
      logic [19:0]        humidity_ten_thousandths;
      logic               pressure_divisor_zero;
   } rsp_beat_type;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TEMPERATURE   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESSURE_LOW  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESSURE_HIGH = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESSURE_LAST = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HUMIDITY      = 3'd4;

   // divider: 64-bit dividend, divisor is a 31-bit signed value
   localparam int NUM_WIDTH = 64;
   localparam int DEN_WIDTH = 31;
   localparam int REM_WIDTH = DEN_WIDTH - 1;

   // results that ride alongside the division
   typedef struct packed {
      logic signed [31:0] temperature;
      logic [19:0]        humidity;
   } div_side_type;

   // divider output control
   typedef struct packed {
      logic valid;
      logic zero;
   } div_status_type;

endpackage

FILE: design/esc_divider.sv
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Restoring division, one quotient bit per stage, truncating toward zero.
// ----------------------------------------------------------------------------
module esc_divider import esc_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic signed [NUM_WIDTH-1:0] in_num,
   input  logic signed [DEN_WIDTH-1:0] in_den,
   input  div_side_type                in_side,
   output div_status_type              out_status,
   output logic signed [NUM_WIDTH-1:0] out_quot,
   output div_side_type                out_side
);

   localparam int STEPS = NUM_WIDTH;

   logic [NUM_WIDTH-1:0] nq_ff   [0:STEPS];
   logic [NUM_WIDTH-1:0] nq_in   [1:STEPS];
   logic [REM_WIDTH-1:0] rem_ff  [0:STEPS];
   logic [REM_WIDTH-1:0] rem_in  [1:STEPS];
   logic [DEN_WIDTH-1:0] dm_ff   [0:STEPS];
   logic                 neg_ff  [0:STEPS];
   logic                 zero_ff [0:STEPS];
   div_side_type         side_ff [0:STEPS];
   logic [STEPS:0]       valid_ff;

   logic signed [NUM_WIDTH-1:0] quot_ff;
   div_side_type                oside_ff;
   logic                        ozero_ff;
   logic                        ovalid_ff;

   logic [NUM_WIDTH-1:0] nmag;
   logic [DEN_WIDTH-1:0] dmag;

   // take magnitudes for the unsigned core
   assign nmag = in_num[NUM_WIDTH-1] ? (~$unsigned(in_num) + 1'b1) : $unsigned(in_num);
   assign dmag = in_den[DEN_WIDTH-1] ? (~$unsigned(in_den) + 1'b1) : $unsigned(in_den);

   // one trial subtraction per stage
   always_comb begin
      logic [DEN_WIDTH-1:0] trial;
      logic [DEN_WIDTH-1:0] diff;
      logic                 ge;
      for (int i = 0; i < STEPS; i++) begin
         trial = {rem_ff[i], nq_ff[i][NUM_WIDTH-1]};
         diff  = trial - dm_ff[i];
         ge    = (trial >= dm_ff[i]);
         rem_in[i+1] = ge ? diff[REM_WIDTH-1:0] : trial[REM_WIDTH-1:0];
         nq_in[i+1]  = {nq_ff[i][NUM_WIDTH-2:0], ge};
      end
   end

   // advance payload through the stages
   always_ff @(posedge clock) begin
      if (advance) begin
         nq_ff[0]   <= nmag;
         rem_ff[0]  <= '0;
         dm_ff[0]   <= dmag;
         neg_ff[0]  <= in_num[NUM_WIDTH-1] ^ in_den[DEN_WIDTH-1];
         zero_ff[0] <= (in_den == '0);
         side_ff[0] <= in_side;
         for (int i = 1; i <= STEPS; i++) begin
            nq_ff[i]   <= nq_in[i];
            rem_ff[i]  <= rem_in[i];
            dm_ff[i]   <= dm_ff[i-1];
            neg_ff[i]  <= neg_ff[i-1];
            zero_ff[i] <= zero_ff[i-1];
            side_ff[i] <= side_ff[i-1];
         end
         // restore the sign
         quot_ff  <= neg_ff[STEPS] ? $signed(~nq_ff[STEPS] + 1'b1) : $signed(nq_ff[STEPS]);
         oside_ff <= side_ff[STEPS];
         ozero_ff <= zero_ff[STEPS];
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff  <= {valid_ff[STEPS-1:0], in_valid};
         ovalid_ff <= valid_ff[STEPS];
      end
   end

   assign out_status.valid = ovalid_ff;
   assign out_status.zero  = ozero_ff;
   assign out_quot         = quot_ff;
   assign out_side         = oside_ff;

endmodule

FILE: design/environmental_sensor_compensation.sv
// ----------------------------------------------------------------------------
// Environmental sensor compensation
// Integer compensation of raw temperature, pressure and humidity readings.
// ----------------------------------------------------------------------------
// Fully pipelined: one sample is accepted every cycle while the response is
// not stalled. A sample passes 15 front stages for fine temperature, humidity
// and the pressure terms, the 66 stages of the divider, whose trial stages
// yield one quotient bit each, and 5 stages of pressure scaling that end in
// the response register. A stall on the response freezes the whole pipeline,
// so nothing is lost or repeated. Calibration registers are read live by the
// front and scaling stages; write them only while no sample is in flight.
module environmental_sensor_compensation import esc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_beat_type               req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_beat_type               rsp_data,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   `include "environmental_sensor_compensation_assert.svh"

   localparam logic signed [32:0] FINE_PRESSURE_OFFSET = 33'sd128000;
   localparam logic signed [31:0] FINE_HUMIDITY_OFFSET = 32'sd76800;
   localparam logic signed [21:0] PRESSURE_BASE        = 22'sd1048576;
   localparam logic signed [63:0] PRESSURE_BIAS        = 64'sh0000_8000_0000_0000;
   localparam logic signed [12:0] PRESSURE_SCALE       = 13'sd3125;
   localparam logic [28:0]        HUMIDITY_MAX         = 29'd419430400;
   localparam logic signed [31:0] HUMIDITY_OFFSET      = 32'sd2097152;
   localparam logic signed [31:0] HUMIDITY_ROUND_LEFT  = 32'sd16384;
   localparam logic signed [31:0] HUMIDITY_ROUND_TERM  = 32'sd32768;
   localparam logic signed [31:0] HUMIDITY_ROUND_RIGHT = 32'sd8192;
   localparam logic signed [31:0] TEMPERATURE_ROUND    = 32'sd1280;
   localparam logic signed [6:0]  TEMPERATURE_SCALE    = 7'sd50;
   localparam logic [39:0]        PRESSURE_MILLI       = 40'd1000;
   localparam logic [13:0]        HUMIDITY_SCALE       = 14'd10000;

   // calibration registers
   logic [47:0] temp_cal_ff;
   logic [63:0] plow_cal_ff;
   logic [63:0] phigh_cal_ff;
   logic [15:0] plast_cal_ff;
   logic [63:0] hum_cal_ff;

   logic                      advance;
   logic [14:0]               stage_valid_ff;
   logic [4:0]                post_valid_ff;

   // calibration fields
   logic [15:0]        t1;
   logic signed [15:0] t2, t3;
   logic [15:0]        p1;
   logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
   logic [7:0]         h1, h3;
   logic signed [15:0] h2;
   logic signed [11:0] h4, h5;
   logic signed [7:0]  h6;

   assign t1 = temp_cal_ff[15:0];
   assign t2 = $signed(temp_cal_ff[31:16]);
   assign t3 = $signed(temp_cal_ff[47:32]);
   assign p1 = plow_cal_ff[15:0];
   assign p2 = $signed(plow_cal_ff[31:16]);
   assign p3 = $signed(plow_cal_ff[47:32]);
   assign p4 = $signed(plow_cal_ff[63:48]);
   assign p5 = $signed(phigh_cal_ff[15:0]);
   assign p6 = $signed(phigh_cal_ff[31:16]);
   assign p7 = $signed(phigh_cal_ff[47:32]);
   assign p8 = $signed(phigh_cal_ff[63:48]);
   assign p9 = $signed(plast_cal_ff);
   assign h1 = hum_cal_ff[7:0];
   assign h2 = $signed(hum_cal_ff[23:8]);
   assign h3 = hum_cal_ff[31:24];
   assign h4 = $signed(hum_cal_ff[43:32]);
   assign h5 = $signed(hum_cal_ff[55:44]);
   assign h6 = $signed(hum_cal_ff[63:56]);

   // write calibration
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff  <= '0;
         plow_cal_ff  <= '0;
         phigh_cal_ff <= '0;
         plast_cal_ff <= '0;
         hum_cal_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TEMPERATURE:   temp_cal_ff  <= csr_write_data[47:0];
            CSR_PRESSURE_LOW:  plow_cal_ff  <= csr_write_data;
            CSR_PRESSURE_HIGH: phigh_cal_ff <= csr_write_data;
            CSR_PRESSURE_LAST: plast_cal_ff <= csr_write_data[15:0];
            CSR_HUMIDITY:      hum_cal_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // hold every stage while the response waits
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // ---- front stage registers ----
   logic signed [18:0] k1_a_ff, k1_b_ff;
   logic [19:0]        k1_adcp_ff, k2_adcp_ff, k3_adcp_ff, k4_adcp_ff, k5_adcp_ff;
   logic [19:0]        k6_adcp_ff, k7_adcp_ff, k8_adcp_ff;
   logic [15:0]        k1_adch_ff, k2_adch_ff, k3_adch_ff, k4_adch_ff, k5_adch_ff;
   logic [15:0]        k6_adch_ff;
   logic signed [31:0] k2_m1_ff, k2_bb_ff;
   logic signed [31:0] k3_m1s_ff, k3_m2_ff;
   logic signed [31:0] k4_tf_ff;
   logic signed [31:0] k5_t50_ff, k5_hx_ff;
   logic signed [32:0] k5_pv1_ff;
   logic signed [31:0] temp_ff [6:15];
   logic signed [63:0] k6_psq_ff;
   logic signed [48:0] k6_pv5_ff, k6_pv2_ff, k7_pv5_ff, k7_pv2_ff;
   logic signed [31:0] k6_h5x_ff, k6_xh6_ff, k6_xh3_ff;
   logic signed [63:0] k7_psq6_ff, k7_psq3_ff;
   logic signed [31:0] k7_hleft_ff, k7_ha_ff, k7_hb_ff;
   logic signed [31:0] k8_hleft_ff, k9_hleft_ff, k10_hleft_ff;
   logic signed [63:0] k8_v2_ff, k8_v1b_ff;
   logic signed [31:0] k8_hprod_ff;
   logic signed [63:0] k9_v1c_ff, k9_np_ff;
   logic signed [31:0] k9_hr_ff;
   logic signed [63:0] num_ff [10:15];
   logic signed [DEN_WIDTH-1:0] den_ff [10:15];
   logic signed [31:0] k10_hright_ff;
   logic signed [31:0] k11_hh_ff, k12_hh_ff, k13_hh_ff;
   logic signed [31:0] k12_hsq_ff, k13_hsh_ff;
   logic [28:0]        k14_hc_ff;
   logic [19:0]        k15_hout_ff;

   // ---- front combinational terms ----
   logic signed [34:0] m1_prod;
   logic signed [37:0] bb_prod;
   logic signed [31:0] bb_shift, m2_shift, m1_shift;
   logic signed [47:0] m2_prod;
   logic signed [38:0] t50_prod;
   logic signed [65:0] psq_prod;
   logic signed [43:0] h5x_prod;
   logic signed [39:0] xh6_prod;
   logic signed [40:0] xh3_prod;
   logic signed [79:0] psq6_prod, psq3_prod;
   logic signed [31:0] hleft_sum;
   logic signed [63:0] pv5_ext, pv2_ext, p4_shift;
   logic signed [63:0] hprod_prod;
   logic signed [63:0] v1_bias;
   logic signed [80:0] v1c_prod;
   logic signed [21:0] p_diff;
   logic signed [63:0] p_shift;
   logic signed [31:0] hr_sum;
   logic signed [47:0] hr_prod;
   logic signed [63:0] den_shift;
   logic signed [76:0] num_prod;
   logic signed [63:0] hh_prod;
   logic signed [31:0] hs_shift, hsq_shift;
   logic signed [63:0] hsq_prod;
   logic signed [40:0] hsh_prod;
   logic signed [31:0] hv;
   logic [42:0]        hout_prod;

   assign m1_prod   = k1_a_ff * t2;
   assign bb_prod   = k1_b_ff * k1_b_ff;
   assign m1_shift  = k2_m1_ff >>> 11;
   assign bb_shift  = k2_bb_ff >>> 12;
   assign m2_prod   = bb_shift * t3;
   assign m2_shift  = k3_m2_ff >>> 14;
   assign t50_prod  = k4_tf_ff * TEMPERATURE_SCALE;
   assign psq_prod  = k5_pv1_ff * k5_pv1_ff;
   assign h5x_prod  = h5 * k5_hx_ff;
   assign xh6_prod  = k5_hx_ff * h6;
   assign xh3_prod  = k5_hx_ff * $signed({1'b0, h3});
   assign psq6_prod = k6_psq_ff * p6;
   assign psq3_prod = k6_psq_ff * p3;
   assign hleft_sum = $signed({2'b00, k6_adch_ff, 14'b0})
                    - $signed({h4, 20'b0}) - k6_h5x_ff + HUMIDITY_ROUND_LEFT;
   assign pv5_ext   = {{15{k7_pv5_ff[48]}}, k7_pv5_ff};
   assign pv2_ext   = {{15{k7_pv2_ff[48]}}, k7_pv2_ff};
   assign p4_shift  = $signed({{13{p4[15]}}, p4, 35'b0});
   assign hprod_prod = k7_ha_ff * k7_hb_ff;
   assign v1_bias   = k8_v1b_ff + PRESSURE_BIAS;
   assign v1c_prod  = v1_bias * $signed({1'b0, p1});
   assign p_diff    = PRESSURE_BASE - $signed({2'b00, k8_adcp_ff});
   assign p_shift   = $signed({{42{p_diff[21]}}, p_diff}) <<< 31;
   assign hr_sum    = (k8_hprod_ff >>> 10) + HUMIDITY_OFFSET;
   assign hr_prod   = hr_sum * h2;
   assign den_shift = k9_v1c_ff >>> 33;
   assign num_prod  = k9_np_ff * PRESSURE_SCALE;
   assign hh_prod   = k10_hleft_ff * k10_hright_ff;
   assign hs_shift  = k11_hh_ff >>> 15;
   assign hsq_prod  = hs_shift * hs_shift;
   assign hsq_shift = k12_hsq_ff >>> 7;
   assign hsh_prod  = hsq_shift * $signed({1'b0, h1});
   assign hv        = k13_hh_ff - (k13_hsh_ff >>> 4);
   assign hout_prod = k14_hc_ff * HUMIDITY_SCALE;

   // advance the front stages
   always_ff @(posedge clock) begin
      if (advance) begin
         // fine temperature
         k1_a_ff    <= $signed({2'b00, req_data.raw_temperature[19:3]})
                     - $signed({2'b00, t1, 1'b0});
         k1_b_ff    <= $signed({3'b000, req_data.raw_temperature[19:4]})
                     - $signed({3'b000, t1});
         k1_adcp_ff <= req_data.raw_pressure;
         k1_adch_ff <= req_data.raw_humidity;
         k2_m1_ff   <= m1_prod[31:0];
         k2_bb_ff   <= bb_prod[31:0];
         k2_adcp_ff <= k1_adcp_ff;
         k2_adch_ff <= k1_adch_ff;
         k3_m1s_ff  <= m1_shift;
         k3_m2_ff   <= m2_prod[31:0];
         k3_adcp_ff <= k2_adcp_ff;
         k3_adch_ff <= k2_adch_ff;
         k4_tf_ff   <= k3_m1s_ff + m2_shift;
         k4_adcp_ff <= k3_adcp_ff;
         k4_adch_ff <= k3_adch_ff;
         k5_t50_ff  <= t50_prod[31:0];
         k5_pv1_ff  <= {k4_tf_ff[31], k4_tf_ff} - FINE_PRESSURE_OFFSET;
         k5_hx_ff   <= k4_tf_ff - FINE_HUMIDITY_OFFSET;
         k5_adcp_ff <= k4_adcp_ff;
         k5_adch_ff <= k4_adch_ff;
         // temperature result and first pressure and humidity products
         temp_ff[6] <= (k5_t50_ff + TEMPERATURE_ROUND) >>> 8;
         for (int i = 7; i <= 15; i++) begin
            temp_ff[i] <= temp_ff[i-1];
         end
         k6_psq_ff  <= psq_prod[63:0];
         k6_pv5_ff  <= k5_pv1_ff * p5;
         k6_pv2_ff  <= k5_pv1_ff * p2;
         k6_h5x_ff  <= h5x_prod[31:0];
         k6_xh6_ff  <= xh6_prod[31:0];
         k6_xh3_ff  <= xh3_prod[31:0];
         k6_adcp_ff <= k5_adcp_ff;
         k6_adch_ff <= k5_adch_ff;
         k7_psq6_ff <= psq6_prod[63:0];
         k7_psq3_ff <= psq3_prod[63:0];
         k7_pv5_ff  <= k6_pv5_ff;
         k7_pv2_ff  <= k6_pv2_ff;
         k7_hleft_ff <= hleft_sum >>> 15;
         k7_ha_ff   <= k6_xh6_ff >>> 10;
         k7_hb_ff   <= (k6_xh3_ff >>> 11) + HUMIDITY_ROUND_TERM;
         k7_adcp_ff <= k6_adcp_ff;
         // pressure sums
         k8_v2_ff    <= k7_psq6_ff + (pv5_ext <<< 17) + p4_shift;
         k8_v1b_ff   <= (k7_psq3_ff >>> 8) + (pv2_ext <<< 12);
         k8_hprod_ff <= hprod_prod[31:0];
         k8_hleft_ff <= k7_hleft_ff;
         k8_adcp_ff  <= k7_adcp_ff;
         k9_v1c_ff   <= v1c_prod[63:0];
         k9_np_ff    <= p_shift - k8_v2_ff;
         k9_hr_ff    <= hr_prod[31:0];
         k9_hleft_ff <= k8_hleft_ff;
         // divider operands
         num_ff[10]    <= num_prod[63:0];
         den_ff[10]    <= den_shift[DEN_WIDTH-1:0];
         k10_hright_ff <= (k9_hr_ff + HUMIDITY_ROUND_RIGHT) >>> 14;
         k10_hleft_ff  <= k9_hleft_ff;
         for (int i = 11; i <= 15; i++) begin
            num_ff[i] <= num_ff[i-1];
            den_ff[i] <= den_ff[i-1];
         end
         // humidity tail
         k11_hh_ff  <= hh_prod[31:0];
         k12_hsq_ff <= hsq_prod[31:0];
         k12_hh_ff  <= k11_hh_ff;
         k13_hsh_ff <= hsh_prod[31:0];
         k13_hh_ff  <= k12_hh_ff;
         if (hv[31]) begin
            k14_hc_ff <= '0;
         end else if ($unsigned(hv) > {3'b000, HUMIDITY_MAX}) begin
            k14_hc_ff <= HUMIDITY_MAX;
         end else begin
            k14_hc_ff <= hv[28:0];
         end
         k15_hout_ff <= hout_prod[41:22];
      end
   end

   // front valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else if (advance) begin
         stage_valid_ff <= {stage_valid_ff[13:0], req_valid};
      end
   end

   // ---- division ----
   div_side_type                div_side;
   div_side_type                div_out_side;
   div_status_type              div_status;
   logic signed [NUM_WIDTH-1:0] div_quot;

   assign div_side.temperature = temp_ff[15];
   assign div_side.humidity    = k15_hout_ff;

   esc_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (stage_valid_ff[14]),
      .in_num     (num_ff[15]),
      .in_den     (den_ff[15]),
      .in_side    (div_side),
      .out_status (div_status),
      .out_quot   (div_quot),
      .out_side   (div_out_side)
   );

   // ---- pressure scaling ----
   logic signed [63:0] d1_q_ff, d2_q_ff, d3_q_ff;
   logic signed [63:0] d1_s_ff, d1_ps9_ff, d1_pv8_ff;
   logic signed [63:0] d2_pv8s_ff, d3_pv8s_ff;
   logic [63:0]        d2_lo_ff;
   logic [31:0]        d2_x1_ff, d2_x2_ff;
   logic signed [63:0] d3_qq_ff;
   logic signed [63:0] d4_pp_ff;
   div_side_type       side_d_ff [1:4];
   logic               zero_d_ff [1:4];
   rsp_beat_type       rsp_ff;

   logic signed [63:0] s_shift;
   logic signed [79:0] ps9_prod, pv8_prod;
   logic [63:0]        lo_prod, x1_prod, x2_prod;
   logic signed [63:0] p7_shift;
   logic [39:0]        pm_prod;

   assign s_shift  = div_quot >>> 13;
   assign ps9_prod = p9 * s_shift;
   assign pv8_prod = p8 * div_quot;
   assign lo_prod  = d1_ps9_ff[31:0] * d1_s_ff[31:0];
   assign x1_prod  = d1_ps9_ff[63:32] * d1_s_ff[31:0];
   assign x2_prod  = d1_ps9_ff[31:0] * d1_s_ff[63:32];
   assign p7_shift = $signed({{44{p7[15]}}, p7, 4'b0});
   assign pm_prod  = d4_pp_ff[39:0] * PRESSURE_MILLI;

   // advance the back stages
   always_ff @(posedge clock) begin
      if (advance) begin
         d1_q_ff      <= div_quot;
         d1_s_ff      <= s_shift;
         d1_ps9_ff    <= ps9_prod[63:0];
         d1_pv8_ff    <= pv8_prod[63:0];
         side_d_ff[1] <= div_out_side;
         zero_d_ff[1] <= div_status.zero;
         for (int i = 2; i <= 4; i++) begin
            side_d_ff[i] <= side_d_ff[i-1];
            zero_d_ff[i] <= zero_d_ff[i-1];
         end
         // low 64 bits of the wide product from 32-bit partials
         d2_lo_ff   <= lo_prod;
         d2_x1_ff   <= x1_prod[31:0];
         d2_x2_ff   <= x2_prod[31:0];
         d2_q_ff    <= d1_q_ff;
         d2_pv8s_ff <= d1_pv8_ff >>> 19;
         d3_qq_ff   <= $signed(d2_lo_ff + {d2_x1_ff + d2_x2_ff, 32'b0});
         d3_q_ff    <= d2_q_ff;
         d3_pv8s_ff <= d2_pv8s_ff;
         d4_pp_ff   <= ((d3_q_ff + (d3_qq_ff >>> 25) + d3_pv8s_ff) >>> 8) + p7_shift;
         // response register
         rsp_ff.temperature_millicelsius <= side_d_ff[4].temperature;
         rsp_ff.humidity_ten_thousandths <= side_d_ff[4].humidity;
         rsp_ff.pressure_divisor_zero    <= zero_d_ff[4];
         rsp_ff.pressure_millipascal     <= zero_d_ff[4] ? 32'd0 : pm_prod[39:8];
      end
   end

   // back valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         post_valid_ff <= '0;
      end else if (advance) begin
         post_valid_ff <= {post_valid_ff[3:0], div_status.valid};
      end
   end

   assign rsp_valid = post_valid_ff[4];
   assign rsp_data  = rsp_ff;

   `ESC_ASSERT_IMPLY(a_stall_back, clock, reset, rsp_valid && rsp_stall, req_stall, "stall not passed back")
   `ESC_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, stage_valid_ff[0], "accepted beat lost")
   `ESC_ASSERT_IMPLY(a_zero_pressure, clock, reset, rsp_valid && rsp_data.pressure_divisor_zero, rsp_data.pressure_millipascal == 32'd0, "pressure not forced to zero")
   `ESC_ASSERT_IMPLY(a_humidity_range, clock, reset, rsp_valid, rsp_data.humidity_ten_thousandths <= 20'd1000000, "humidity out of range")

endmodule
